### src/arr_pkg.sv
// ----------------------------------------------------------------------------
// arr_pkg
// Shared constants, register map and mode codes of the audio rate reducer.
// ----------------------------------------------------------------------------
package arr_pkg;

  localparam int MAX_FACTOR = 128;
  localparam int SAMPLE_W   = 16;
  localparam int QUANT_BITS = 8;
  localparam int DIGIT_W    = SAMPLE_W - QUANT_BITS;
  localparam int FACTOR_W   = $clog2(MAX_FACTOR + 1);
  localparam int PHASE_W    = $clog2(MAX_FACTOR);
  localparam int PROD_W     = DIGIT_W + PHASE_W;
  localparam int RF_W       = 8;
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd2;

  localparam logic REG_RATE_FACTOR = 1'b0;
  localparam logic REG_MODE        = 1'b1;

  localparam logic [RF_W-1:0] RATE_FACTOR_RESET = 8'd2;

endpackage

### src/arr_mul.sv
// ----------------------------------------------------------------------------
// arr_mul
// Shift-add multiplier: difference magnitude times phase, one phase bit per
// cycle.
// ----------------------------------------------------------------------------
module arr_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [arr_pkg::DIGIT_W-1:0]      mcand_i,
  input  logic [arr_pkg::PHASE_W-1:0]      mplier_i,
  output logic                             done_o,
  output logic [arr_pkg::PROD_W-1:0]       prod_o
);

  localparam int CNT_W = $clog2(arr_pkg::PHASE_W + 1);

  logic [arr_pkg::PROD_W-1:0]  mcand_q, mcand_d;
  logic [arr_pkg::PHASE_W-1:0] mplier_q, mplier_d;
  logic [arr_pkg::PROD_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        done_q, done_d;

  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    if (start_i) begin
      mcand_d  = arr_pkg::PROD_W'(mcand_i);
      mplier_d = mplier_i;
      acc_d    = '0;
      cnt_d    = CNT_W'(arr_pkg::PHASE_W);
    end else if (cnt_q != '0) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[arr_pkg::PROD_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[arr_pkg::PHASE_W-1:1]};
      cnt_d    = cnt_q - CNT_W'(1);
      done_d   = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### src/arr_div.sv
// ----------------------------------------------------------------------------
// arr_div
// Restoring divider by the rate factor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arr_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [arr_pkg::FACTOR_W-1:0]      rem_init_i,
  input  logic [arr_pkg::SAMPLE_W-1:0]      dividend_lo_i,
  input  logic [arr_pkg::FACTOR_W-1:0]      divisor_i,
  output logic                              done_o,
  output logic [arr_pkg::SAMPLE_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(arr_pkg::SAMPLE_W + 1);

  logic [arr_pkg::FACTOR_W-1:0] rem_q, rem_d;
  logic [arr_pkg::FACTOR_W-1:0] dsr_q, dsr_d;
  logic [arr_pkg::SAMPLE_W-1:0] sh_q, sh_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic [arr_pkg::FACTOR_W:0]   trial;
  logic                         qbit;

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, sh_q[arr_pkg::SAMPLE_W-1]};
    qbit   = (trial >= {1'b0, dsr_q});
    if (start_i) begin
      rem_d = rem_init_i;
      dsr_d = divisor_i;
      sh_d  = dividend_lo_i;
      cnt_d = CNT_W'(arr_pkg::SAMPLE_W);
    end else if (cnt_q != '0) begin
      if (qbit) begin
        rem_d = arr_pkg::FACTOR_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[arr_pkg::FACTOR_W-1:0];
      end
      sh_d   = {sh_q[arr_pkg::SAMPLE_W-2:0], qbit};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

### src/audio_rate_reducer.sv
// ----------------------------------------------------------------------------
// audio_rate_reducer
// Keeps one sample in N, quantized to its upper byte, and rebuilds the full
// rate stream by zero stuffing, hold or linear interpolation.
// ----------------------------------------------------------------------------
// One result beat per input beat. Zero stuffing and hold bypass the multiplier
// and divider. In linear mode the interpolation step (b-a)*k/N runs through a
// shift-add multiplier that takes one phase bit per cycle and a restoring
// divider by N that produces one quotient bit per cycle. The block works on
// one beat at a time; a finished result waits in the output register while
// the next beat is taken.
module audio_rate_reducer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [arr_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [arr_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [arr_pkg::ADDR_W-1:0]        paddr,
  input  logic [arr_pkg::DATA_W-1:0]        pwdata,
  output logic [arr_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam int SW = arr_pkg::SAMPLE_W;
  localparam int DW = arr_pkg::DIGIT_W;
  localparam int FW = arr_pkg::FACTOR_W;
  localparam int PW = arr_pkg::PHASE_W;
  localparam int QB = arr_pkg::QUANT_BITS;

  state_e                      state_q;
  logic [arr_pkg::RF_W-1:0]    rate_factor_q;
  logic [arr_pkg::MODE_W-1:0]  mode_q;
  logic [PW-1:0]               phase_q;
  logic [SW-1:0]               newer_q, older_q;
  logic [FW-1:0]               n_q;
  logic                        neg_q;
  logic [SW-1:0]               res_q;
  logic                        out_valid_q;
  logic [SW-1:0]               sample_out_q;

  logic                        accept, cfg_wr, out_load;
  logic [FW-1:0]               n_eff;
  logic [FW-1:0]               k_ext, k_next;
  logic [PW-1:0]               k;
  logic                        k_zero;
  logic [SW-1:0]               newer_d, older_d;
  logic signed [DW:0]          diff;
  logic [DW:0]                 diff_abs;
  logic [SW-1:0]               res_now;
  logic                        mul_start, mul_done, div_done;
  logic [arr_pkg::PROD_W-1:0]  prod;
  logic [SW-1:0]               quot;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      arr_pkg::REG_RATE_FACTOR: prdata = arr_pkg::DATA_W'(rate_factor_q);
      arr_pkg::REG_MODE:        prdata = arr_pkg::DATA_W'(mode_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_factor_q <= arr_pkg::RATE_FACTOR_RESET;
      mode_q        <= arr_pkg::MODE_ZERO;
    end else if (cfg_wr) begin
      if (paddr[2] == arr_pkg::REG_RATE_FACTOR) begin
        rate_factor_q <= pwdata[arr_pkg::RF_W-1:0];
      end else begin
        mode_q <= pwdata[arr_pkg::MODE_W-1:0];
      end
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // effective factor and phase
  always_comb begin
    if (rate_factor_q == '0) begin
      n_eff = FW'(1);
    end else if (FW'(rate_factor_q) > FW'(arr_pkg::MAX_FACTOR)) begin
      n_eff = FW'(arr_pkg::MAX_FACTOR);
    end else begin
      n_eff = FW'(rate_factor_q);
    end
    k_ext  = (FW'(phase_q) >= n_eff) ? '0 : FW'(phase_q);
    k      = k_ext[PW-1:0];
    k_zero = (k_ext == '0);
    k_next = ((k_ext + FW'(1)) >= n_eff) ? '0 : k_ext + FW'(1);
  end

  always_comb begin
    if (k_zero) begin
      older_d = newer_q;
      newer_d = {sample_in_i[SW-1:QB], {QB{1'b0}}};
    end else begin
      older_d = older_q;
      newer_d = newer_q;
    end
    diff     = $signed({newer_d[SW-1], newer_d[SW-1:QB]})
             - $signed({older_d[SW-1], older_d[SW-1:QB]});
    diff_abs = diff[DW] ? (DW+1)'(-diff) : diff;
    case (mode_q)
      arr_pkg::MODE_ZERO: res_now = k_zero ? newer_d : '0;
      default:            res_now = newer_d;
    endcase
  end

  assign mul_start = accept && (mode_q == arr_pkg::MODE_LINEAR);

  arr_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (diff_abs[DW-1:0]),
    .mplier_i (k),
    .done_o   (mul_done),
    .prod_o   (prod)
  );

  arr_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (mul_done),
    .rem_init_i    (FW'(prod[arr_pkg::PROD_W-1:DW])),
    .dividend_lo_i ({prod[DW-1:0], {QB{1'b0}}}),
    .divisor_i     (n_q),
    .done_o        (div_done),
    .quot_o        (quot)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      newer_q     <= '0;
      older_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            phase_q <= k_next[PW-1:0];
            newer_q <= newer_d;
            older_q <= older_d;
            state_q <= (mode_q == arr_pkg::MODE_LINEAR) ? ST_MUL : ST_OUT;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q   <= n_eff;
      neg_q <= diff[DW];
      res_q <= res_now;
    end else if ((state_q == ST_DIV) && div_done) begin
      res_q <= neg_q ? (older_q - quot) : (older_q + quot);
    end
    if (out_load) begin
      sample_out_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for audio_rate_reducer. Samples go in through the
// valid/stall input channel and the rebuilt samples are checked in order
// against a cycle-free predictor of decimation, quantization and zero
// stuffing, hold or linear rebuild. The rate factor and mode are changed
// over the APB port between drained phases, including zero, oversized and
// lowered factors and the spare mode code. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = arr_pkg::SAMPLE_W;
  localparam int QUANT_BITS = arr_pkg::QUANT_BITS;
  localparam int PHASE_W    = arr_pkg::PHASE_W;
  localparam int RF_W       = arr_pkg::RF_W;
  localparam int MODE_W     = arr_pkg::MODE_W;
  localparam int ADDR_W     = arr_pkg::ADDR_W;
  localparam int DATA_W     = arr_pkg::DATA_W;
  localparam int MAX_FACTOR = arr_pkg::MAX_FACTOR;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_BEATS = 1750;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 64;

  class rebuild_checker;
    logic [RF_W-1:0]              factor_reg;
    logic [MODE_W-1:0]            mode_reg;
    logic [PHASE_W-1:0]           phase;
    logic signed [SAMPLE_W-1:0]   newer;
    logic signed [SAMPLE_W-1:0]   older;
    logic signed [SAMPLE_W-1:0]   rebuilt_q[$];
    int unsigned                  mismatches;

    function new();
      factor_reg = arr_pkg::RATE_FACTOR_RESET;
      mode_reg   = arr_pkg::MODE_ZERO;
      phase      = '0;
      newer      = '0;
      older      = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return rebuilt_q.size();
    endfunction

    // predicts the rebuilt sample for one accepted input beat
    function void note_sample(logic signed [SAMPLE_W-1:0] value);
      int n;
      int k;
      int diff;
      int res;
      logic signed [SAMPLE_W-1:0] want;
      n = factor_reg;
      if (n == 0) n = 1;
      if (n > MAX_FACTOR) n = MAX_FACTOR;
      k = phase;
      if (k >= n) k = 0;
      if (k == 0) begin
        older = newer;
        newer = {value[SAMPLE_W-1:QUANT_BITS], {QUANT_BITS{1'b0}}};
      end
      case (mode_reg)
        arr_pkg::MODE_ZERO: begin
          res = (k == 0) ? int'(newer) : 0;
        end
        arr_pkg::MODE_LINEAR: begin
          diff = int'(newer) - int'(older);
          res  = int'(older) + (diff * k) / n;
        end
        default: begin
          res = int'(newer);
        end
      endcase
      k = k + 1;
      if (k >= n) k = 0;
      phase = k[PHASE_W-1:0];
      want  = res[SAMPLE_W-1:0];
      rebuilt_q.push_back(want);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_sample(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (rebuilt_q.size() == 0) begin
        report($sformatf("sample_out %0d with no beat outstanding", got));
      end else begin
        want = rebuilt_q.pop_front();
        if (got !== want) report($sformatf("sample_out %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic signed [SAMPLE_W-1:0]   sample_in_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_out_o;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [ADDR_W-1:0]            paddr = '0;
  logic [DATA_W-1:0]            pwdata = '0;
  logic [DATA_W-1:0]            prdata;
  logic                         pready;

  rebuild_checker book = new();
  bit          gaps_on = 1'b1;
  int unsigned quiet_cycles = 0;
  int unsigned beats_sent = 0;

  audio_rate_reducer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) book.check_sample(sample_out_o);
    out_stall_i <= gaps_on && ($urandom_range(99) < 34);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    if (gaps_on && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 34);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    book.note_sample(value);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == arr_pkg::REG_RATE_FACTOR) begin
      book.factor_reg = value[RF_W-1:0];
    end else begin
      book.mode_reg = value[MODE_W-1:0];
    end
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [RF_W-1:0] factor, input logic [MODE_W-1:0] md);
    drain_results();
    write_reg(arr_pkg::REG_RATE_FACTOR, DATA_W'(factor));
    write_reg(arr_pkg::REG_MODE, DATA_W'(md));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(SAMPLE_W'($urandom));
  endtask

  initial begin
    int phase_no;
    int count;
    logic [RF_W-1:0] factor;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, field extremes
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(-16'sh0001);
    send_sample(16'sh0000);
    // every sample kept
    configure(8'd1, arr_pkg::MODE_HOLD);
    send_sample(-16'sh7f01);
    send_sample(16'sh7f00);
    // linear with full-scale swings
    configure(8'd3, arr_pkg::MODE_LINEAR);
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    // zero factor acts as one, spare mode acts as hold
    configure(8'd0, MODE_SPARE);
    send_random(2);
    // oversized factor clamps
    configure(8'd255, arr_pkg::MODE_ZERO);
    send_random(2);
    // lowered factor with phase past the new end
    configure(8'd5, arr_pkg::MODE_HOLD);
    send_random(3);
    configure(8'd2, arr_pkg::MODE_HOLD);
    send_random(2);
    configure(8'd8, arr_pkg::MODE_LINEAR);
    send_random(4);
    configure(8'd3, arr_pkg::MODE_LINEAR);
    send_random(2);

    beats_sent = 0;
    phase_no   = 0;
    while (beats_sent < RANDOM_BEATS) begin
      case ($urandom_range(9))
        0: factor = RF_W'($urandom_range(0, 255));
        1, 2: begin
          case ($urandom_range(4))
            0: factor = 8'd0;
            1: factor = 8'd1;
            2: factor = 8'd128;
            3: factor = 8'd129;
            default: factor = 8'd255;
          endcase
        end
        default: factor = RF_W'($urandom_range(1, 8));
      endcase
      configure(factor, MODE_W'($urandom_range(0, 3)));
      gaps_on = (phase_no < 3 || phase_no > 7);
      count = (factor > 8) ? $urandom_range(40, 260) : $urandom_range(10, 80);
      if (count > RANDOM_BEATS - int'(beats_sent)) count = RANDOM_BEATS - int'(beats_sent);
      for (int i = 0; i < count; i++) begin
        if (i == count / 2 && (phase_no == 0 || $urandom_range(3) == 0)) drain_results();
        send_sample(SAMPLE_W'($urandom));
      end
      phase_no++;
    end

    gaps_on = 1'b1;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### audio_rate_reducer.f
src/arr_pkg.sv
src/arr_mul.sv
src/arr_div.sv
src/audio_rate_reducer.sv
test/testbench.sv
